// ----- design/ttsu_pkg.sv -----
// Shared types, widths and codes for the timer table scheduler.
package ttsu_pkg;

  localparam int unsigned MAX_TIMERS_DEF = 16;
  localparam int unsigned TIME_W         = 48;
  localparam int unsigned ID_W           = 32;
  localparam int unsigned HDL_W          = 8;
  localparam int unsigned IV_W           = 32;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_STOP   = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REMOVING = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [HDL_W-1:0]  handler;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [IV_W-1:0]   interval;
  } entry_t;

endpackage

// ----- design/ttsu_sat_add.sv -----
// Saturating add of a 32-bit interval to a 48-bit time.
module ttsu_sat_add
  import ttsu_pkg::*;
(
  input  logic [TIME_W-1:0] base,
  input  logic [IV_W-1:0]   delta,
  output logic [TIME_W-1:0] sum
);

  logic [TIME_W:0] raw;

  assign raw = {1'b0, base} + {{(TIME_W + 1 - IV_W){1'b0}}, delta};
  // clamp at the top of the time range
  assign sum = raw[TIME_W] ? {TIME_W{1'b1}} : raw[TIME_W-1:0];

endmodule

// ----- design/timer_table_scheduler_unit.sv -----
// Timer table scheduler: slot store, compaction scan and cached earliest deadline.
// Sequence: an add passes through S_ADD and S_FIN, an ignored tick goes straight to S_FIN;
// stop, remove and expiring ticks make one pass over the slot memory in S_SCAN through its
// registered read port, one slot a cycle, then S_FIN.
// Throughput: one word at a time; busy drops as done rises, so the next word can be taken
// at the edge that takes the result. done marks the result for one cycle; no stall.
// Reset (rst, synchronous) empties the table and clears id counter and cached deadline.
module timer_table_scheduler_unit
  import ttsu_pkg::*;
#(
  parameter int unsigned MAX_TIMERS = MAX_TIMERS_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [HDL_W-1:0]  handler,
  input  logic              handler_removing,
  input  logic [IV_W-1:0]   interval,
  input  logic              single_shot,
  input  logic [ID_W-1:0]   stop_id,
  input  logic [TIME_W-1:0] now,
  output logic              done,
  output logic [1:0]        status,
  output logic [ID_W-1:0]   tmr_id,
  output logic              fired,
  output logic [HDL_W-1:0]  fired_handler,
  output logic              deadline_valid,
  output logic [TIME_W-1:0] next_deadline
);

  localparam int unsigned CW = $clog2(MAX_TIMERS + 1);
  localparam int unsigned AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_SCAN, S_FIN} state_t;

  state_t state;

  // latched input word
  kind_t             kind_q;
  logic [HDL_W-1:0]  handler_q;
  logic              removing_q;
  logic [IV_W-1:0]   interval_q;
  logic              single_shot_q;
  logic [ID_W-1:0]   stop_id_q;
  logic [TIME_W-1:0] now_q;

  // architectural state
  logic [CW-1:0]     count;
  logic [ID_W-1:0]   id_counter;
  logic              earliest_valid;
  logic [TIME_W-1:0] earliest_deadline;

  // scan state
  logic [CW-1:0]     rd_ptr;
  logic [CW-1:0]     wr_ptr;
  logic              rd_pend;
  logic [AW-1:0]     rd_idx;
  logic              found;
  logic              scanned;
  logic              min_valid;
  logic [TIME_W-1:0] min_deadline;
  logic [AW-1:0]     hit_idx;
  entry_t            hit_entry;
  logic              cand_valid;
  logic [TIME_W-1:0] cand_deadline;

  // result under construction
  logic [1:0]        res_status;
  logic [ID_W-1:0]   res_id;

  // slot memory
  entry_t            slots [MAX_TIMERS];
  entry_t            rd_data;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  entry_t            mem_wd;
  logic              rd_issue;

  // shared saturating adder: add interval on an add word, reload interval on a tick
  logic [IV_W-1:0]   add_delta;
  logic [TIME_W-1:0] add_sum;

  ttsu_sat_add u_sat_add (
    .base  (now_q),
    .delta (add_delta),
    .sum   (add_sum)
  );

  assign add_delta = (state == S_ADD) ? interval_q : rd_data.interval;

  assign busy = (state != S_IDLE);

  // id for an accepted add: count up, skip zero
  logic [ID_W-1:0] id_next;
  assign id_next = (id_counter == {ID_W{1'b1}}) ? {{(ID_W-1){1'b0}}, 1'b1}
                                                : id_counter + 1'b1;

  logic add_ok;
  assign add_ok = !removing_q && (count < CW'(MAX_TIMERS));

  // per-slot decision during the scan
  logic slot_del;
  logic slot_first;
  logic slot_expired;

  assign rd_issue     = (state == S_SCAN) && (rd_ptr < count);
  assign slot_expired = (rd_data.deadline <= now_q);

  always_comb begin
    slot_del   = 1'b0;
    slot_first = 1'b0;
    unique case (kind_q)
      KIND_STOP: begin
        slot_del = (stop_id_q != '0) && !found && (rd_data.id == stop_id_q);
      end
      KIND_REMOVE: begin
        slot_del = (rd_data.handler == handler_q);
      end
      KIND_TICK: begin
        slot_first = slot_expired && !found;
        slot_del   = slot_first && (rd_data.interval == '0);
      end
      KIND_ADD: begin
        slot_del = 1'b0;
      end
    endcase
  end

  // memory write port: new slot, compaction move, or reload of the fired slot
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_data;
    unique case (state)
      S_ADD: begin
        mem_we = add_ok;
        mem_wa = count[AW-1:0];
        mem_wd = '{handler:  handler_q,
                   id:       id_next,
                   deadline: add_sum,
                   interval: single_shot_q ? '0 : interval_q};
      end
      S_SCAN: begin
        mem_we = rd_pend && !slot_del;
        mem_wa = wr_ptr[AW-1:0];
        mem_wd = rd_data;
      end
      S_FIN: begin
        mem_we = (kind_q == KIND_TICK) && cand_valid;
        mem_wa = hit_idx;
        mem_wd = hit_entry;
        mem_wd.deadline = cand_deadline;
      end
      S_IDLE: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots[mem_wa] <= mem_wd;
    end
    if (rd_issue) begin
      rd_data <= slots[rd_ptr[AW-1:0]];
    end
  end

  // final deadline update: start from the scan minimum on an expiring tick,
  // fold in the new candidate, clear when the table is empty
  logic              base_v;
  logic [TIME_W-1:0] base_d;
  logic              fin_v;
  logic [TIME_W-1:0] fin_d;

  always_comb begin
    if (scanned && (kind_q == KIND_TICK)) begin
      base_v = min_valid;
      base_d = min_deadline;
    end else begin
      base_v = earliest_valid;
      base_d = earliest_deadline;
    end
    fin_v = base_v;
    fin_d = base_d;
    if (cand_valid && (!base_v || (cand_deadline < base_d))) begin
      fin_v = 1'b1;
      fin_d = cand_deadline;
    end
    if (count == '0) begin
      fin_v = 1'b0;
    end
    if (!fin_v) begin
      fin_d = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      count             <= '0;
      id_counter        <= '0;
      earliest_valid    <= 1'b0;
      earliest_deadline <= '0;
      done              <= 1'b0;
      rd_pend           <= 1'b0;
      found             <= 1'b0;
      scanned           <= 1'b0;
      cand_valid        <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            // latch the word and prime the scan
            kind_q        <= kind_t'(kind);
            handler_q     <= handler;
            removing_q    <= handler_removing;
            interval_q    <= interval;
            single_shot_q <= single_shot;
            stop_id_q     <= stop_id;
            now_q         <= now;
            rd_ptr        <= '0;
            wr_ptr        <= '0;
            rd_pend       <= 1'b0;
            found         <= 1'b0;
            min_valid     <= 1'b0;
            cand_valid    <= 1'b0;
            res_status    <= ST_OK;
            res_id        <= '0;
            hit_entry     <= '0;
            unique case (kind_t'(kind))
              KIND_ADD: begin
                state   <= S_ADD;
                scanned <= 1'b0;
              end
              KIND_TICK: begin
                // skip the pass when nothing can have expired yet
                if (earliest_valid && (now >= earliest_deadline)) begin
                  state   <= S_SCAN;
                  scanned <= 1'b1;
                end else begin
                  state   <= S_FIN;
                  scanned <= 1'b0;
                end
              end
              KIND_STOP, KIND_REMOVE: begin
                state   <= S_SCAN;
                scanned <= 1'b1;
              end
            endcase
          end
        end

        S_ADD: begin
          // append the slot and hand its deadline to the final update
          priority if (removing_q) begin
            res_status <= ST_REMOVING;
          end else if (!add_ok) begin
            res_status <= ST_FULL;
          end else begin
            id_counter    <= id_next;
            res_id        <= id_next;
            count         <= count + 1'b1;
            cand_valid    <= 1'b1;
            cand_deadline <= add_sum;
          end
          state <= S_FIN;
        end

        S_SCAN: begin
          // advance the read pointer, one slot a cycle
          if (rd_issue) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          rd_pend <= rd_issue;
          rd_idx  <= rd_ptr[AW-1:0];
          if (rd_pend) begin
            if (!slot_del) begin
              wr_ptr <= wr_ptr + 1'b1;
            end
            if (kind_q == KIND_STOP && slot_del) begin
              found <= 1'b1;
            end
            if (kind_q == KIND_TICK) begin
              if (slot_first) begin
                // fire the first expired slot; hold it for the reload
                found     <= 1'b1;
                hit_idx   <= rd_idx;
                hit_entry <= rd_data;
                res_id    <= rd_data.id;
                if (rd_data.interval != '0) begin
                  cand_valid    <= 1'b1;
                  cand_deadline <= add_sum;
                end
              end else if (!min_valid || (rd_data.deadline < min_deadline)) begin
                min_valid    <= 1'b1;
                min_deadline <= rd_data.deadline;
              end
            end
          end
          if (!rd_issue && !rd_pend) begin
            count <= wr_ptr;
            state <= S_FIN;
          end
        end

        S_FIN: begin
          // commit the cached deadline and present the result word
          earliest_valid    <= fin_v;
          earliest_deadline <= fin_d;
          status            <= res_status;
          tmr_id            <= res_id;
          fired             <= (kind_q == KIND_TICK) && found;
          fired_handler     <= ((kind_q == KIND_TICK) && found) ? hit_entry.handler : '0;
          deadline_valid    <= fin_v;
          next_deadline     <= fin_d;
          state             <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- dv/timer_table_scheduler_unit_tb.sv -----
// Self-checking testbench for the timer table scheduler: directed and random command words.
module timer_table_scheduler_unit_tb;
  import ttsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One command word as presented on the input ports.
  typedef struct packed {
    logic [1:0]        kind;
    logic [HDL_W-1:0]  handler;
    logic              removing;
    logic [IV_W-1:0]   interval;
    logic              single_shot;
    logic [ID_W-1:0]   stop_id;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // One result word as seen on the output ports.
  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   tmr_id;
    logic              fired;
    logic [HDL_W-1:0]  fired_handler;
    logic              dl_valid;
    logic [TIME_W-1:0] next_dl;
  } outcome_t;

  // Keeps a private copy of the timer table, works out the result of every
  // accepted command and compares it with what the block returns.
  class timer_scoreboard;
    logic [HDL_W-1:0]  tab_handler [MAX_TIMERS_DEF];
    logic [ID_W-1:0]   tab_id      [MAX_TIMERS_DEF];
    logic [TIME_W-1:0] tab_dl      [MAX_TIMERS_DEF];
    logic [IV_W-1:0]   tab_iv      [MAX_TIMERS_DEF];
    int unsigned       live;
    logic [ID_W-1:0]   id_ctr;
    logic [TIME_W-1:0] earliest;
    bit                earliest_ok;
    outcome_t          pending[$];
    int fails, words, effective, adds_ok, rej_removing, rej_full, fires, removes;

    function new();
      live = 0;
      id_ctr = '0;
      earliest = '0;
      earliest_ok = 0;
      fails = 0; words = 0; effective = 0; adds_ok = 0;
      rej_removing = 0; rej_full = 0; fires = 0; removes = 0;
    endfunction

    function logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] t, logic [IV_W-1:0] d);
      logic [TIME_W:0] s;
      s = {1'b0, t} + {{(TIME_W-IV_W+1){1'b0}}, d};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function void delete_slot(int unsigned k);
      for (int unsigned j = k; j + 1 < live; j++) begin
        tab_handler[j] = tab_handler[j+1];
        tab_id[j]      = tab_id[j+1];
        tab_dl[j]      = tab_dl[j+1];
        tab_iv[j]      = tab_iv[j+1];
      end
      live--;
    endfunction

    function void clear_if_empty();
      if (live == 0) begin
        earliest_ok = 0;
        earliest = '0;
      end
    endfunction

    function void take_min(logic [TIME_W-1:0] d);
      if (!earliest_ok || d < earliest) begin
        earliest = d;
        earliest_ok = 1;
      end
    endfunction

    // An id that is in the table now, or a random one if the table is empty.
    function logic [ID_W-1:0] any_live_id();
      if (live == 0) return $urandom;
      return tab_id[$urandom_range(0, live - 1)];
    endfunction

    function void note(cmd_t c);
      outcome_t    e;
      int unsigned hit;
      int unsigned k;
      bit          acted;
      e = '0;
      acted = 1;
      case (c.kind)
        KIND_ADD: begin
          if (c.removing) begin
            e.status = ST_REMOVING;
            rej_removing++;
          end else if (live >= MAX_TIMERS_DEF) begin
            e.status = ST_FULL;
            rej_full++;
          end else begin
            id_ctr++;
            if (id_ctr == '0) id_ctr = 1;
            tab_handler[live] = c.handler;
            tab_id[live]      = id_ctr;
            tab_dl[live]      = sat_add(c.now, c.interval);
            tab_iv[live]      = c.single_shot ? '0 : c.interval;
            take_min(tab_dl[live]);
            live++;
            e.tmr_id = id_ctr;
            adds_ok++;
          end
        end
        KIND_STOP: begin
          acted = 0;
          if (c.stop_id != '0) begin
            for (k = 0; k < live; k++) begin
              if (tab_id[k] == c.stop_id) begin
                delete_slot(k);
                clear_if_empty();
                acted = 1;
                break;
              end
            end
          end
        end
        KIND_REMOVE: begin
          k = 0;
          while (k < live) begin
            if (tab_handler[k] == c.handler) delete_slot(k);
            else k++;
          end
          clear_if_empty();
          removes++;
        end
        default: begin
          acted = 0;
          if (earliest_ok && c.now >= earliest) begin
            acted = 1;
            hit = live;
            earliest_ok = 0;
            earliest = '0;
            for (k = 0; k < live; k++) begin
              if (!earliest_ok || tab_dl[k] < earliest) begin
                if (tab_dl[k] <= c.now) begin
                  hit = k;
                  break;
                end
                earliest = tab_dl[k];
                earliest_ok = 1;
              end
            end
            if (hit < live) begin
              for (k = hit + 1; k < live; k++) take_min(tab_dl[k]);
              e.fired = 1'b1;
              e.tmr_id = tab_id[hit];
              e.fired_handler = tab_handler[hit];
              fires++;
              if (tab_iv[hit] == '0) begin
                delete_slot(hit);
              end else begin
                tab_dl[hit] = sat_add(c.now, tab_iv[hit]);
                take_min(tab_dl[hit]);
              end
            end
            clear_if_empty();
            if (!earliest_ok) earliest = '0;
          end
        end
      endcase
      e.dl_valid = earliest_ok;
      e.next_dl = earliest_ok ? earliest : '0;
      pending.push_back(e);
      words++;
      if (acted) effective++;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] MISMATCH %s: got %0h, want %0h", $time, what, got, want);
      fails++;
    endtask

    task check(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        report("result word with nothing outstanding", got.tmr_id, 0);
      end else begin
        want = pending[0];
        pending.delete(0);
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.tmr_id !== want.tmr_id) report("tmr_id", got.tmr_id, want.tmr_id);
        if (got.fired !== want.fired) report("fired", got.fired, want.fired);
        if (got.fired_handler !== want.fired_handler)
          report("fired_handler", got.fired_handler, want.fired_handler);
        if (got.dl_valid !== want.dl_valid)
          report("deadline_valid", got.dl_valid, want.dl_valid);
        if (got.next_dl !== want.next_dl) report("next_deadline", got.next_dl, want.next_dl);
      end
    endtask
  endclass

  // Stimulus side of the block; every input starts at a known value.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        kind = KIND_TICK;
  logic [HDL_W-1:0]  handler = '0;
  logic              handler_removing = 1'b0;
  logic [IV_W-1:0]   interval = '0;
  logic              single_shot = 1'b0;
  logic [ID_W-1:0]   stop_id = '0;
  logic [TIME_W-1:0] now = '0;

  logic              busy;
  logic              done;
  logic [1:0]        status;
  logic [ID_W-1:0]   tmr_id;
  logic              fired;
  logic [HDL_W-1:0]  fired_handler;
  logic              deadline_valid;
  logic [TIME_W-1:0] next_deadline;

  timer_scoreboard   sb;
  int                burst_left = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  timer_table_scheduler_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .handler        (handler),
    .handler_removing(handler_removing),
    .interval       (interval),
    .single_shot    (single_shot),
    .stop_id        (stop_id),
    .now            (now),
    .done           (done),
    .status         (status),
    .tmr_id         (tmr_id),
    .fired          (fired),
    .fired_handler  (fired_handler),
    .deadline_valid (deadline_valid),
    .next_deadline  (next_deadline)
  );

  // 12 ns period: low half then high half.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Sample at the rising edge. Settle a returning word before noting a new one,
  // since both can land on the same edge and the old word was accepted first.
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check('{status, tmr_id, fired, fired_handler, deadline_valid, next_deadline});
      if (start && !busy)
        sb.note('{kind, handler, handler_removing, interval, single_shot, stop_id, now});
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  // Completely random word: used as noise on the ports while idle and as the
  // starting point for every random command.
  function automatic cmd_t any_word();
    cmd_t c;
    c.kind        = 2'($urandom_range(0, 3));
    c.handler     = HDL_W'($urandom);
    c.removing    = 1'($urandom_range(0, 1));
    c.interval    = $urandom;
    c.single_shot = 1'($urandom_range(0, 1));
    c.stop_id     = $urandom;
    c.now         = rand_time();
    return c;
  endfunction

  function automatic cmd_t mk(logic [1:0] k, logic [HDL_W-1:0] h, logic rm,
                              logic [IV_W-1:0] iv, logic os, logic [ID_W-1:0] sid,
                              logic [TIME_W-1:0] t);
    cmd_t c;
    c = '{k, h, rm, iv, os, sid, t};
    return c;
  endfunction

  // Mostly a small pool of handlers so that removals find something to drop.
  function automatic logic [HDL_W-1:0] pick_handler();
    if ($urandom_range(0, 4) == 0) return HDL_W'($urandom);
    return HDL_W'($urandom_range(0, 3));
  endfunction

  // Well-formed traffic around a running millisecond clock: adds at the current
  // time, ticks that move the clock forward, stops of live ids, removals.
  function automatic cmd_t make_word();
    cmd_t c;
    int   r;
    int   sel;
    c = any_word();
    r = $urandom_range(0, 99);
    if (r < 40) begin
      c.kind = KIND_ADD;
      c.handler = pick_handler();
      c.removing = ($urandom_range(0, 9) == 0);
      sel = $urandom_range(0, 9);
      if (sel == 0) c.interval = '0;
      else if (sel > 1) c.interval = $urandom_range(1, 60);
      c.now = clock_ms;
    end else if (r < 75) begin
      c.kind = KIND_TICK;
      clock_ms = clock_ms + TIME_W'($urandom_range(0, 25));
      if ($urandom_range(0, 19) != 0) c.now = clock_ms;
    end else if (r < 92) begin
      c.kind = KIND_STOP;
      sel = $urandom_range(0, 9);
      if (sel == 0) c.stop_id = '0;
      else if (sel > 1) c.stop_id = sb.any_live_id();
    end else begin
      c.kind = KIND_REMOVE;
      c.handler = pick_handler();
    end
    return c;
  endfunction

  // Present one word and hold it until the block takes it, then either keep
  // start high for the next word of the burst or drop it for a random gap.
  task automatic send(input cmd_t c);
    int gap;
    cmd_t noise;
    {kind, handler, handler_removing, interval, single_shot, stop_id, now} = c;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      noise = any_word();
      start = 1'b0;
      {kind, handler, handler_removing, interval, single_shot, stop_id, now} = noise;
      // Mostly short idle gaps, now and then a longer one.
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 25) : $urandom_range(0, 6);
      repeat (gap) @(negedge clk);
      // Every so often a long burst with no idling at all.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] base;
    int                sent;
    int                waited;
    outcome_t          left;
    sb = new();
    base = 48'h0000_1000_0000;
    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: empty tick, add while removing, saturated deadline, periodic
    // with zero interval, stop of zero and of an unknown id, removal to empty.
    send(mk(KIND_TICK, 8'h00, 1'b0, '0, 1'b0, '0, '1));
    send(mk(KIND_ADD, 8'h5A, 1'b1, 32'd100, 1'b0, '0, '0));
    send(mk(KIND_ADD, 8'hFF, 1'b0, '1, 1'b0, '0, '1));
    send(mk(KIND_ADD, 8'h00, 1'b0, '0, 1'b0, '0, '0));
    send(mk(KIND_TICK, 8'h00, 1'b0, '0, 1'b0, '0, '0));
    send(mk(KIND_STOP, 8'h00, 1'b0, '0, 1'b0, '0, '0));
    send(mk(KIND_STOP, 8'h00, 1'b0, '0, 1'b0, '1, '0));
    send(mk(KIND_REMOVE, 8'hFF, 1'b0, '0, 1'b0, '0, '0));
    // Fill the table, then hit it full, and full while removing.
    for (int k = 0; k < MAX_TIMERS_DEF; k++)
      send(mk(KIND_ADD, 8'(k % 2 + 1), 1'b0, 32'(10 * (k + 1)), (k % 3 == 0), '0, base));
    send(mk(KIND_ADD, 8'h07, 1'b0, 32'd5, 1'b0, '0, base));
    send(mk(KIND_ADD, 8'h07, 1'b1, 32'd5, 1'b0, '0, base));
    // Stop the earliest timer and tick at its old deadline: nothing expired,
    // but the cached deadline gets recomputed. Then a tick before the deadline.
    send(mk(KIND_STOP, 8'h00, 1'b0, '0, 1'b0, sb.tab_id[0], '0));
    send(mk(KIND_TICK, 8'h00, 1'b0, '0, 1'b0, '0, base + 10));
    send(mk(KIND_TICK, 8'h00, 1'b0, '0, 1'b0, '0, base + 5));
    send(mk(KIND_TICK, 8'h00, 1'b0, '0, 1'b0, '0, base + 100));
    send(mk(KIND_REMOVE, 8'h01, 1'b0, '0, 1'b0, '0, '0));
    send(mk(KIND_REMOVE, 8'h02, 1'b0, '0, 1'b0, '0, '0));

    // Random: about 1700 words; jump the clock now and then to a fresh region,
    // near zero, anywhere, or close to saturation.
    sent = 0;
    while (sent < 1700) begin
      if (sent % 150 == 0) begin
        case ($urandom_range(0, 3))
          0: clock_ms = TIME_W'($urandom_range(0, 100));
          1: clock_ms = rand_time();
          2: clock_ms = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 500));
          default: ;
        endcase
      end
      send(make_word());
      sent++;
    end
    start = 1'b0;

    // Drain: wait for the last words, then give the block time to misbehave.
    waited = 0;
    while (sb.pending.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    while (sb.pending.size() != 0) begin
      left = sb.pending[0];
      sb.pending.delete(0);
      sb.report("result word never returned", 0, left.tmr_id);
    end

    $display("Covered %0d words (%0d with an effect): %0d adds, %0d rejected removing,",
             sb.words, sb.effective, sb.adds_ok, sb.rej_removing);
    $display("  %0d rejected full, %0d timers fired, %0d handler removals, %0d mismatches.",
             sb.rej_full, sb.fires, sb.removes, sb.fails);
    if (sb.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ttsu_pkg.sv
design/ttsu_sat_add.sv
design/timer_table_scheduler_unit.sv
dv/timer_table_scheduler_unit_tb.sv
